@@ rtl/core/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-256 shared definitions
// S-box tables, GF(2^8) helpers, round-step functions and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumWords  = 60;
    localparam int NumRounds = 14;
    localparam int WordIdxW  = 6;
    localparam int RoundW    = 4;

    localparam logic [7:0] XtPoly   = 8'h1B;
    localparam logic [7:0] RconInit = 8'h01;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic                start;
        logic                enc;
        logic                key_load;
        logic                key_step;
        logic [WordIdxW-1:0] key_idx;
        logic                rnd_first;
        logic                rnd_mid;
        logic                rnd_last;
    } t_cmd;

    typedef struct packed {
        logic key_done;
    } t_stat;

    function automatic logic [7:0] sbox(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    // inverse S-box: x -> A^-1 (x ^ 0x63) in affine form, then GF inverse
    // taken through the forward table's structure is avoided; use direct map.
    function automatic logic [7:0] inv_sbox(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; default: r=8'h7d;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? XtPoly : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
    endfunction

    function automatic t_block sub_bytes(input t_block s, input logic enc);
        t_block r;
        for (int k = 0; k < 16; k++) begin
            r[8*k +: 8] = enc ? sbox(s[8*k +: 8]) : inv_sbox(s[8*k +: 8]);
        end
        return r;
    endfunction

    function automatic t_block shift_rows(input t_block s, input logic enc);
        t_block r;
        for (int c = 0; c < 4; c++) begin
            for (int q = 0; q < 4; q++) begin
                r[8*(4*c+q) +: 8] = enc ? s[8*(4*((c+q)%4)+q) +: 8]
                                        : s[8*(4*((c+4-q)%4)+q) +: 8];
            end
        end
        return r;
    endfunction

    function automatic t_block mix_columns(input t_block s, input logic enc);
        t_block r;
        logic [7:0] a0, a1, a2, a3, u, v, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[8*(4*c)   +: 8];
            a1 = s[8*(4*c+1) +: 8];
            a2 = s[8*(4*c+2) +: 8];
            a3 = s[8*(4*c+3) +: 8];
            if (!enc) begin
                u  = xt(xt(a0 ^ a2));
                v  = xt(xt(a1 ^ a3));
                a0 = a0 ^ u;
                a2 = a2 ^ u;
                a1 = a1 ^ v;
                a3 = a3 ^ v;
            end
            al = a0 ^ a1 ^ a2 ^ a3;
            r[8*(4*c)   +: 8] = a0 ^ al ^ xt(a0 ^ a1);
            r[8*(4*c+1) +: 8] = a1 ^ al ^ xt(a1 ^ a2);
            r[8*(4*c+2) +: 8] = a2 ^ al ^ xt(a2 ^ a3);
            r[8*(4*c+3) +: 8] = a3 ^ al ^ xt(a3 ^ a0);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/aes256_block_cipher.sv @@
// ----------------------------------------------------------------------------
// AES-256 block cipher
// ECB encrypt or decrypt of one 128-bit block with a 256-bit configured key.
// ----------------------------------------------------------------------------
// A block is taken, then the initial key addition and the 14 rounds run,
// one round key row read from the round-key memory per cycle, and the
// result is held until its transfer; the next block can be taken the cycle
// after that transfer. The schedule is expanded again one word per cycle, a
// load step and then words 8 to 59, after reset and after any key write (by
// way of the idle state there), before the next block is taken; a key write
// during expansion restarts it.
module aes256_block_cipher
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high
);

    logic [63:0]  r_key [4];
    logic         key_wr;
    t_cmd         cmd;
    t_stat        stat;
    logic [127:0] state;

    assign o_cfg_ready = 1'b1;
    assign key_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '{default: '0};
        end else if (key_wr) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    aes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_wr    (key_wr),
        .i_in_valid  (i_valid),
        .i_in_enc    (i_action),
        .i_out_stall (i_stall),
        .i_stat      (stat),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    aes_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   ({r_key[3], r_key[2], r_key[1], r_key[0]}),
        .i_cmd   (cmd),
        .i_block ({i_block_high, i_block_low}),
        .o_stat  (stat),
        .o_state (state)
    );

    assign o_result_low  = state[63:0];
    assign o_result_high = state[127:64];

endmodule

@@ rtl/core/aes_datapath.sv @@
// ----------------------------------------------------------------------------
// AES-256 datapath
// Key expansion into a 15-row round-key memory and the round state register.
// One round key row (four words) is read per cycle, registered.
// ----------------------------------------------------------------------------
module aes_datapath
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [255:0] i_key,
    input  t_cmd         i_cmd,
    input  logic [127:0] i_block,
    output t_stat        o_stat,
    output logic [127:0] o_state
);

    localparam int Rows = NumRounds + 1;

    logic [127:0] mem_rk [Rows];
    logic [127:0] r_rk;
    logic [127:0] r_state;
    logic [255:0] r_win;
    logic [7:0]   r_rcon;
    logic [WordIdxW-1:0] r_widx;
    logic [RoundW-1:0]   n_rd;
    logic [31:0]  w_new;
    logic [31:0]  w_tmp;
    logic [255:0] n_win;

    // one new schedule word per cycle from the eight-word window
    always_comb begin
        w_tmp = r_win[255:224];
        if (r_widx[2:0] == 3'd0) begin
            w_tmp = sub_word({w_tmp[7:0], w_tmp[31:8]}) ^ {24'd0, r_rcon};
        end else if (r_widx[2:0] == 3'd4) begin
            w_tmp = sub_word(w_tmp);
        end
        w_new = r_win[31:0] ^ w_tmp;
        n_win = {w_new, r_win[255:32]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_rcon <= RconInit;
            r_widx <= '0;
        end else if (i_cmd.key_load) begin
            r_win  <= i_key;
            r_rcon <= RconInit;
            r_widx <= WordIdxW'(8);
        end else if (i_cmd.key_step) begin
            r_win  <= n_win;
            r_widx <= r_widx + 1'b1;
            if (r_widx[2:0] == 3'd0) begin
                r_rcon <= xt(r_rcon);
            end
        end
    end

    // write rows: initial key gives rows 0,1; each fourth new word ends a row
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            mem_rk[0] <= i_key[127:0];
            mem_rk[1] <= i_key[255:128];
        end else if (i_cmd.key_step && r_widx[1:0] == 2'd3) begin
            mem_rk[r_widx[WordIdxW-1:2]] <= {w_new, r_win[255:160]};
        end
    end

    always_comb begin
        n_rd = i_cmd.key_idx[RoundW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_rk <= mem_rk[n_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_state <= i_block;
        end else if (i_cmd.rnd_first) begin
            r_state <= r_state ^ r_rk;
        end else if (i_cmd.rnd_mid) begin
            if (i_cmd.enc) begin
                r_state <= mix_columns(shift_rows(sub_bytes(r_state, 1'b1), 1'b1), 1'b1)
                           ^ r_rk;
            end else begin
                r_state <= mix_columns(sub_bytes(shift_rows(r_state, 1'b0), 1'b0)
                                       ^ r_rk, 1'b0);
            end
        end else if (i_cmd.rnd_last) begin
            if (i_cmd.enc) begin
                r_state <= shift_rows(sub_bytes(r_state, 1'b1), 1'b1) ^ r_rk;
            end else begin
                r_state <= sub_bytes(shift_rows(r_state, 1'b0), 1'b0) ^ r_rk;
            end
        end
    end

    assign o_stat.key_done = (r_widx == WordIdxW'(NumWords - 1));
    assign o_state         = r_state;

endmodule

@@ rtl/core/aes_ctrl.sv @@
// ----------------------------------------------------------------------------
// AES-256 controller
// Sequences key expansion, the 15 round steps and the output transfer.
// ----------------------------------------------------------------------------
module aes_ctrl
    import aes_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_key_wr,
    input  logic  i_in_valid,
    input  logic  i_in_enc,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_KEY, S_FETCH, S_ROUND, S_OUT
    } t_state;

    t_state            r_st;
    logic              r_fresh;
    logic              r_enc;
    logic [RoundW-1:0] r_rnd;
    logic              r_load;
    logic              take;

    assign take        = (r_st == S_IDLE) && r_fresh && i_in_valid;
    assign o_in_stall  = !((r_st == S_IDLE) && r_fresh);
    assign o_out_valid = (r_st == S_OUT);

    always_comb begin
        o_cmd           = '0;
        o_cmd.enc       = r_enc;
        o_cmd.start     = take;
        o_cmd.key_load  = r_load;
        o_cmd.key_step  = (r_st == S_KEY) && !r_load;
        // key row for next cycle
        if (take) begin
            o_cmd.key_idx = i_in_enc ? WordIdxW'(0) : WordIdxW'(NumRounds);
        end else begin
            o_cmd.key_idx = r_enc ? WordIdxW'(r_rnd + 1'b1)
                                  : WordIdxW'(RoundW'(NumRounds - 1) - r_rnd);
        end
        o_cmd.rnd_first = (r_st == S_ROUND) && (r_rnd == '0);
        o_cmd.rnd_mid   = (r_st == S_ROUND) && (r_rnd != '0)
                          && (r_rnd != RoundW'(NumRounds));
        o_cmd.rnd_last  = (r_st == S_ROUND) && (r_rnd == RoundW'(NumRounds));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_KEY;
            r_load  <= 1'b1;
            r_fresh <= 1'b0;
            r_rnd   <= '0;
            r_enc   <= 1'b0;
        end else begin
            if (i_key_wr) begin
                r_fresh <= 1'b0;
            end else if (r_st == S_KEY && !r_load && i_stat.key_done) begin
                r_fresh <= 1'b1;
            end
            case (r_st)
                S_IDLE: begin
                    r_load <= !r_fresh && !i_key_wr;
                    if (!r_fresh && !i_key_wr) begin
                        r_st <= S_KEY;
                    end else if (take) begin
                        r_enc <= i_in_enc;
                        r_rnd <= '0;
                        r_st  <= S_ROUND;
                    end
                end
                S_KEY: begin
                    // a key write during expansion restarts it
                    r_load <= i_key_wr;
                    if (!i_key_wr && !r_load && i_stat.key_done) begin
                        r_st <= S_IDLE;
                    end
                end
                S_ROUND: begin
                    r_load <= 1'b0;
                    r_rnd  <= r_rnd + 1'b1;
                    if (r_rnd == RoundW'(NumRounds)) begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_load <= 1'b0;
                    if (!i_out_stall) begin
                        r_st <= S_IDLE;
                    end
                end
                default: begin
                    r_load <= 1'b0;
                    r_st   <= S_IDLE;
                end
            endcase
        end
    end

    property p_no_take_stale;
        @(posedge i_clk) disable iff (!i_rst_n) take |-> r_fresh;
    endproperty
    a_no_take_stale: assert property (p_no_take_stale) else $error("stale schedule");

    property p_round_ends;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_st == S_ROUND && r_rnd == RoundW'(NumRounds)) |=> (r_st == S_OUT);
    endproperty
    a_round_ends: assert property (p_round_ends) else $error("round count");

    property p_take_starts;
        @(posedge i_clk) disable iff (!i_rst_n) take |=> (r_st == S_ROUND && r_rnd == '0);
    endproperty
    a_take_starts: assert property (p_take_starts) else $error("start");

endmodule

@@ verif/aes256_block_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// AES-256 block cipher testbench
// Drives encrypt and decrypt blocks under several keys with random gaps and
// output stalls, predicts each result in-bench and checks it field by field.
// ----------------------------------------------------------------------------
module aes256_block_cipher_tb
    import aes_pkg::*;
;

    typedef struct packed {
        logic        action;
        logic [63:0] blk_low;
        logic [63:0] blk_high;
    } t_item;

    typedef struct packed {
        logic [63:0] res_low;
        logic [63:0] res_high;
    } t_res;

    localparam logic ACT_DEC = 1'b0;
    localparam logic ACT_ENC = 1'b1;
    localparam logic [1:0] KEY_W0 = 2'd0;
    localparam logic [1:0] KEY_W1 = 2'd1;
    localparam logic [1:0] KEY_W2 = 2'd2;
    localparam logic [1:0] KEY_W3 = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = KEY_W0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = 1'b0;
    logic [63:0] i_block_low = '0;
    logic [63:0] i_block_high = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_result_low;
    logic [63:0] o_result_high;

    aes256_block_cipher uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [7:0]  fwd_tbl [256];
    logic [7:0]  rev_tbl [256];
    logic [63:0] key_regs [4];
    logic [31:0] sched [60];

    t_item pending_q[$];
    t_res  expected_q[$];
    int    mismatch_cnt = 0;
    int    hold_cycles = 0;
    bit    hold_go = 0;
    bit    hold_used = 0;
    bit    feed_done = 0;

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    // GF(2^8) inverse by exhaustive search, then the affine transform
    task automatic build_sboxes();
        logic [7:0] inv, x, p, q;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++) begin
                p = 8'h00;
                q = 8'(a);
                for (int k = 0; k < 8; k++) begin
                    if (b[k]) p ^= q;
                    q = gmul2(q);
                end
                if (p == 8'h01) inv = 8'(b);
            end
            x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_tbl[a] = x;
            rev_tbl[x] = 8'(a);
        end
    endtask

    function automatic logic [31:0] sub4(input logic [31:0] w);
        return {fwd_tbl[w[31:24]], fwd_tbl[w[23:16]], fwd_tbl[w[15:8]], fwd_tbl[w[7:0]]};
    endfunction

    task automatic expand_schedule();
        logic [31:0] x;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) sched[i] = key_regs[i/2][32*(i%2) +: 32];
        for (int i = 8; i < 60; i++) begin
            x = sched[i-1];
            if (i % 8 == 0) begin
                x = sub4({x[7:0], x[31:8]}) ^ {24'h0, rc};
                rc = gmul2(rc);
            end else if (i % 8 == 4) begin
                x = sub4(x);
            end
            sched[i] = sched[i-8] ^ x;
        end
    endtask

    function automatic t_block add_rk(input t_block s, input int rnd);
        for (int k = 0; k < 16; k++) s[8*k +: 8] ^= sched[rnd*4 + k/4][8*(k%4) +: 8];
        return s;
    endfunction

    function automatic t_block subst(input t_block s, input logic enc);
        for (int k = 0; k < 16; k++)
            s[8*k +: 8] = enc ? fwd_tbl[s[8*k +: 8]] : rev_tbl[s[8*k +: 8]];
        return s;
    endfunction

    function automatic t_block rotate_rows(input t_block s, input logic enc);
        t_block t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[8*(4*c+r) +: 8] = s[8*(4*(enc ? (c+r)%4 : (c+4-r)%4)+r) +: 8];
        return t;
    endfunction

    function automatic t_block mix_cols(input t_block s, input logic enc);
        logic [7:0] a [4];
        logic [7:0] u, v, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = s[8*(4*c+r) +: 8];
            if (!enc) begin
                u = gmul2(gmul2(a[0] ^ a[2]));
                v = gmul2(gmul2(a[1] ^ a[3]));
                a[0] ^= u; a[2] ^= u; a[1] ^= v; a[3] ^= v;
            end
            al = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++)
                s[8*(4*c+r) +: 8] = a[r] ^ al ^ gmul2(a[r] ^ a[(r+1)%4]);
        end
        return s;
    endfunction

    function automatic t_res cipher_block(input t_item it);
        t_block s;
        s = {it.blk_high, it.blk_low};
        if (it.action == ACT_ENC) begin
            s = add_rk(s, 0);
            for (int r = 1; r < 14; r++)
                s = add_rk(mix_cols(rotate_rows(subst(s, 1'b1), 1'b1), 1'b1), r);
            s = add_rk(rotate_rows(subst(s, 1'b1), 1'b1), 14);
        end else begin
            s = add_rk(s, 14);
            for (int r = 13; r > 0; r--)
                s = mix_cols(add_rk(subst(rotate_rows(s, 1'b0), 1'b0), r), 1'b0);
            s = add_rk(subst(rotate_rows(s, 1'b0), 1'b0), 0);
        end
        return '{res_low: s[63:0], res_high: s[127:64]};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_q.push_back(cipher_block('{i_action, i_block_low, i_block_high}));
                void'(pending_q.pop_front());
                send_gap <= $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
                if (pending_q.size() > 0 && send_gap == 0 && $urandom_range(0, 1)) begin
                    i_action     <= pending_q[0].action;
                    i_block_low  <= pending_q[0].blk_low;
                    i_block_high <= pending_q[0].blk_high;
                end else begin
                    i_valid <= 1'b0;
                end
            end else if (!i_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_q.size() > 0) begin
                    i_valid      <= 1'b1;
                    i_action     <= pending_q[0].action;
                    i_block_low  <= pending_q[0].blk_low;
                    i_block_high <= pending_q[0].blk_high;
                end
            end
        end
    end

    // long receiver hold, counted on its own
    always @(posedge i_clk) begin
        if (hold_go && !hold_used) begin
            hold_used   <= 1'b1;
            hold_cycles <= 300;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected result transfer");
                end else begin
                    want = expected_q.pop_front();
                    if (want.res_low !== o_result_low || want.res_high !== o_result_high) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result: exp %h_%h got %h_%h", want.res_high,
                                     want.res_low, o_result_high, o_result_low);
                    end
                end
                stall_left <= $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
                i_stall <= 1'b1;
            end else if (hold_cycles > 0) begin
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        key_regs[idx] = val;
    endtask

    task automatic set_key(input logic [63:0] k0, k1, k2, k3);
        write_key(KEY_W0, k0);
        write_key(KEY_W1, k1);
        write_key(KEY_W2, k2);
        write_key(KEY_W3, k3);
        expand_schedule();
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !i_valid);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic void push_item(input logic act, input logic [63:0] lo, hi);
        pending_q.push_back('{act, lo, hi});
    endfunction

    function automatic void push_random(input int n);
        logic [63:0] lo, hi;
        for (int i = 0; i < n; i++) begin
            lo = rand64();
            hi = rand64();
            case ($urandom_range(0, 5))
                0: lo = '0;
                1: hi = '1;
                default: ;
            endcase
            push_item(1'($urandom_range(0, 1)), lo, hi);
        end
    endfunction

    initial begin
        build_sboxes();
        for (int i = 0; i < 4; i++) key_regs[i] = '0;
        expand_schedule();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero key, extremes and both directions
        push_item(ACT_ENC, '0, '0);
        push_item(ACT_DEC, '0, '0);
        push_item(ACT_ENC, '1, '1);
        push_item(ACT_DEC, '1, '1);
        push_item(ACT_ENC, 64'h8877665544332211, 64'h00ffeeddccbbaa99);
        push_item(ACT_DEC, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
        drain();

        set_key('1, '1, '1, '1);
        push_item(ACT_ENC, '0, '1);
        push_item(ACT_DEC, '1, '0);
        drain();

        set_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
        push_item(ACT_ENC, 64'h7766554433221100, 64'hffeeddccbbaa9988);
        push_item(ACT_DEC, 64'hbf456751cab7a28e, 64'h8960494b9049fcea);
        // long receiver hold while the sender keeps offering
        hold_go = 1;
        push_random(20);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_key(rand64(), rand64(), rand64(), rand64());
            push_random(100);
            drain();
        end
        feed_done = 1;
    end

    initial begin
        wait (feed_done);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
